// ----- rtl/assert_macros.svh -----
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/mrte_pkg.sv -----
// ----------------------------------------------------------------------------
// mrte_pkg
// Types and constants shared by the R-type execute block.
// ----------------------------------------------------------------------------
package mrte_pkg;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  instr_class;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_write;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        overflow;
    logic [31:0] hi_out;
    logic [31:0] lo_out;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic        divide;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } md_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_res_t;

  localparam logic [5:0] F_SLL   = 6'h00;
  localparam logic [5:0] F_SRL   = 6'h02;
  localparam logic [5:0] F_SRA   = 6'h03;
  localparam logic [5:0] F_SLLV  = 6'h04;
  localparam logic [5:0] F_SRLV  = 6'h06;
  localparam logic [5:0] F_SRAV  = 6'h07;
  localparam logic [5:0] F_JR    = 6'h08;
  localparam logic [5:0] F_MFHI  = 6'h10;
  localparam logic [5:0] F_MTHI  = 6'h11;
  localparam logic [5:0] F_MFLO  = 6'h12;
  localparam logic [5:0] F_MTLO  = 6'h13;
  localparam logic [5:0] F_MULT  = 6'h18;
  localparam logic [5:0] F_MULTU = 6'h19;
  localparam logic [5:0] F_DIV   = 6'h1A;
  localparam logic [5:0] F_DIVU  = 6'h1B;
  localparam logic [5:0] F_ADD   = 6'h20;
  localparam logic [5:0] F_ADDU  = 6'h21;
  localparam logic [5:0] F_SUB   = 6'h22;
  localparam logic [5:0] F_SUBU  = 6'h23;
  localparam logic [5:0] F_AND   = 6'h24;
  localparam logic [5:0] F_OR    = 6'h25;
  localparam logic [5:0] F_XOR   = 6'h26;
  localparam logic [5:0] F_SLT   = 6'h2A;
  localparam logic [5:0] F_SLTU  = 6'h2B;

  localparam logic [1:0] CLASS_R = 2'd0;
  localparam logic [1:0] CLASS_J = 2'd1;
  localparam logic [1:0] CLASS_I = 2'd2;

endpackage

// ----- rtl/mrte_muldiv.sv -----
// ----------------------------------------------------------------------------
// mrte_muldiv
// Shared iterative multiply and divide unit, one bit per cycle.
// ----------------------------------------------------------------------------
module mrte_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  mrte_pkg::md_cmd_t cmd,
  output mrte_pkg::md_res_t res
);
  import mrte_pkg::*;
  `include "assert_macros.svh"

  logic        busy;
  logic [5:0]  count;
  logic        divide;
  logic        neg_q;
  logic        neg_r;
  logic [31:0] mag_b;
  logic [63:0] acc;
  logic [32:0] trial;
  logic [32:0] sum;
  logic [63:0] fin;
  logic [31:0] q_fix;
  logic [31:0] r_fix;
  logic [31:0] ma;
  logic [31:0] mb;
  logic        done;

  assign ma = (cmd.sgn && cmd.a[31]) ? 32'd0 - cmd.a : cmd.a;
  assign mb = (cmd.sgn && cmd.b[31]) ? 32'd0 - cmd.b : cmd.b;

  assign trial = {acc[63:31]} - {1'b0, mag_b};
  assign sum   = {1'b0, acc[63:32]} + (acc[0] ? {1'b0, mag_b} : 33'd0);

  assign q_fix = neg_q ? 32'd0 - acc[31:0] : acc[31:0];
  assign r_fix = neg_r ? 32'd0 - acc[63:32] : acc[63:32];
  assign fin   = neg_q ? 64'd0 - acc : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 6'd1;
      if (count == 6'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      divide <= cmd.divide;
      mag_b  <= mb;
      neg_q  <= cmd.sgn && (cmd.a[31] ^ cmd.b[31]);
      neg_r  <= cmd.sgn && cmd.a[31];
      acc    <= {32'd0, ma};
    end else if (busy) begin
      if (divide) begin
        if (!trial[32]) begin
          acc <= {trial[31:0], acc[30:0], 1'b1};
        end else begin
          acc <= {acc[62:0], 1'b0};
        end
      end else begin
        acc <= {sum, acc[31:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && count == 6'd31;
    end
  end

  always_comb begin
    res.done = done;
    res.hi   = divide ? r_fix : fin[63:32];
    res.lo   = divide ? q_fix : fin[31:0];
  end

  `ASSERT_IMPLIES(a_no_start_busy, clk, rst, cmd.start, !busy)
  `ASSERT_NEXT(a_done_pulse, clk, rst, res.done, !res.done)
  `ASSERT_NEXT(a_done_after_last, clk, rst, busy && count == 6'd31, res.done)
endmodule

// ----- rtl/mips_r_type_execute.sv -----
// ----------------------------------------------------------------------------
// mips_r_type_execute
// MIPS32 R-type execute stage with HI/LO registers.
// ----------------------------------------------------------------------------
// A request carries an instruction word and its rs and rt register values.
// One response follows each request on the output channel.
// Functions that do not start the multiply/divide unit respond in the cycle after acceptance.
// MULT, MULTU, and DIV and DIVU with a nonzero divisor use a shared
// shift-add/subtract unit that retires one bit per cycle, and respond when it is done.
// The block takes one request at a time; in_stall is high after acceptance
// until the response has been taken.
// The response is held in an output register while out_stall is high.
// Reset clears HI, LO and all control state; no request is in flight.
// Signed multiply and divide run on magnitudes with a sign fix at the end.
// ----------------------------------------------------------------------------
module mips_r_type_execute (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mrte_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mrte_pkg::rsp_t out_data
);
  import mrte_pkg::*;
  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state;
  logic [31:0] hi;
  logic [31:0] lo;
  rsp_t        rsp_next;
  logic [31:0] hi_next;
  logic [31:0] lo_next;
  md_cmd_t     cmd;
  md_res_t     mres;
  logic        accept;
  logic        md_op;
  logic [5:0]  funct;
  logic [31:0] a;
  logic [31:0] b;
  logic [32:0] add_r;
  logic [32:0] sub_r;
  logic [4:0]  sh;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign funct    = in_data.instruction[5:0];
  assign a        = in_data.rs_value;
  assign b        = in_data.rt_value;
  assign add_r    = {1'b0, a} + {1'b0, b};
  assign sub_r    = {1'b0, a} - {1'b0, b};
  assign sh       = (funct[2]) ? a[4:0] : in_data.instruction[10:6];

  always_comb begin
    rsp_next = '0;
    hi_next = hi;
    lo_next = lo;
    md_op = 1'b0;
    rsp_next.dest_index = in_data.instruction[15:11];
    if (in_data.instruction[31:26] == 6'd0) begin
      rsp_next.instr_class = CLASS_R;
    end else if (in_data.instruction[31:26] == 6'd2 || in_data.instruction[31:26] == 6'd3) begin
      rsp_next.instr_class = CLASS_J;
    end else begin
      rsp_next.instr_class = CLASS_I;
    end
    if (rsp_next.instr_class == CLASS_R) begin
      rsp_next.dest_write = 1'b1;
      case (funct)
        F_ADD: begin
          if ((a[31] == b[31]) && (add_r[31] != a[31])) begin
            rsp_next.overflow = 1'b1;
            rsp_next.dest_write = 1'b0;
          end else begin
            rsp_next.dest_value = add_r[31:0];
          end
        end
        F_ADDU: rsp_next.dest_value = add_r[31:0];
        F_SUB: begin
          if ((a[31] != b[31]) && (sub_r[31] != a[31])) begin
            rsp_next.overflow = 1'b1;
            rsp_next.dest_write = 1'b0;
          end else begin
            rsp_next.dest_value = sub_r[31:0];
          end
        end
        F_SUBU: rsp_next.dest_value = sub_r[31:0];
        F_AND: rsp_next.dest_value = a & b;
        F_OR: rsp_next.dest_value = a | b;
        F_XOR: rsp_next.dest_value = a ^ b;
        F_SLT: rsp_next.dest_value = {31'd0, ($signed(a) < $signed(b))};
        F_SLTU: rsp_next.dest_value = {31'd0, sub_r[32]};
        F_SLL, F_SLLV: rsp_next.dest_value = b << sh;
        F_SRL, F_SRLV: rsp_next.dest_value = b >> sh;
        F_SRA, F_SRAV: rsp_next.dest_value = 32'($signed(b) >>> sh);
        F_JR: begin
          rsp_next.dest_write = 1'b0;
          rsp_next.jump_taken = 1'b1;
          rsp_next.jump_target = a;
        end
        F_MFHI: rsp_next.dest_value = hi;
        F_MFLO: rsp_next.dest_value = lo;
        F_MTHI: begin
          rsp_next.dest_write = 1'b0;
          hi_next = a;
        end
        F_MTLO: begin
          rsp_next.dest_write = 1'b0;
          lo_next = a;
        end
        F_MULT, F_MULTU: begin
          rsp_next.dest_write = 1'b0;
          md_op = 1'b1;
        end
        F_DIV, F_DIVU: begin
          rsp_next.dest_write = 1'b0;
          md_op = (b != 32'd0);
        end
        default: rsp_next.dest_write = 1'b0;
      endcase
    end
    rsp_next.hi_out = hi_next;
    rsp_next.lo_out = lo_next;
  end

  assign cmd.start  = accept && md_op;
  assign cmd.divide = funct[1];
  assign cmd.sgn    = !funct[0];
  assign cmd.a      = a;
  assign cmd.b      = b;

  mrte_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hi <= '0;
      lo <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_data <= rsp_next;
            hi <= hi_next;
            lo <= lo_next;
            state <= md_op ? S_MD : S_OUT;
          end
        end
        S_MD: begin
          if (mres.done) begin
            hi <= mres.hi;
            lo <= mres.lo;
            out_data.hi_out <= mres.hi;
            out_data.lo_out <= mres.lo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state == S_OUT);

  `ASSERT_IMPLIES(a_done_in_md, clk, rst, mres.done, state == S_MD)
  `ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_IMPLIES(a_out_hilo, clk, rst, out_valid, out_data.hi_out == hi && out_data.lo_out == lo)
endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the MIPS R-type execute block.
// ----------------------------------------------------------------------------
// An initial block builds a queue of requests: a directed set of corner cases
// followed by random R-type, jump and immediate words. A clocked driver sends
// them and a clocked monitor compares every response with a prediction that
// tracks HI and LO. Sender and receiver idle at random in two of three phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mrte_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  mips_r_type_execute dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [31:0] model_hi;
  logic [31:0] model_lo;
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit stim_done;

  localparam int WATCHDOG_LIMIT = 20000;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t predict_execute(req_t r);
    rsp_t o;
    logic [5:0] opc, fn;
    logic [31:0] a, b, t, ma, mb, q, rm;
    logic [63:0] p;
    logic na, nb;
    a = r.rs_value;
    b = r.rt_value;
    opc = r.instruction[31:26];
    fn = r.instruction[5:0];
    o = '0;
    o.dest_index = r.instruction[15:11];
    if (opc == 6'd0) o.instr_class = CLASS_R;
    else if (opc == 6'd2 || opc == 6'd3) o.instr_class = CLASS_J;
    else o.instr_class = CLASS_I;
    if (o.instr_class == CLASS_R) begin
      case (fn)
        F_ADD: begin
          t = a + b;
          if (a[31] == b[31] && t[31] != a[31]) o.overflow = 1'b1;
          else begin o.dest_value = t; o.dest_write = 1'b1; end
        end
        F_SUB: begin
          t = a - b;
          if (a[31] != b[31] && t[31] != a[31]) o.overflow = 1'b1;
          else begin o.dest_value = t; o.dest_write = 1'b1; end
        end
        F_ADDU: begin o.dest_value = a + b; o.dest_write = 1'b1; end
        F_SUBU: begin o.dest_value = a - b; o.dest_write = 1'b1; end
        F_AND: begin o.dest_value = a & b; o.dest_write = 1'b1; end
        F_OR: begin o.dest_value = a | b; o.dest_write = 1'b1; end
        F_XOR: begin o.dest_value = a ^ b; o.dest_write = 1'b1; end
        F_SLT: begin
          o.dest_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          o.dest_write = 1'b1;
        end
        F_SLTU: begin o.dest_value = (a < b) ? 32'd1 : 32'd0; o.dest_write = 1'b1; end
        F_SLL: begin o.dest_value = b << r.instruction[10:6]; o.dest_write = 1'b1; end
        F_SRL: begin o.dest_value = b >> r.instruction[10:6]; o.dest_write = 1'b1; end
        F_SRA: begin
          o.dest_value = $signed(b) >>> r.instruction[10:6];
          o.dest_write = 1'b1;
        end
        F_SLLV: begin o.dest_value = b << a[4:0]; o.dest_write = 1'b1; end
        F_SRLV: begin o.dest_value = b >> a[4:0]; o.dest_write = 1'b1; end
        F_SRAV: begin o.dest_value = $signed(b) >>> a[4:0]; o.dest_write = 1'b1; end
        F_JR: begin o.jump_taken = 1'b1; o.jump_target = a; end
        F_MFHI: begin o.dest_value = model_hi; o.dest_write = 1'b1; end
        F_MFLO: begin o.dest_value = model_lo; o.dest_write = 1'b1; end
        F_MTHI: model_hi = a;
        F_MTLO: model_lo = a;
        F_MULT: begin
          p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          {model_hi, model_lo} = p;
        end
        F_MULTU: begin
          p = {32'd0, a} * {32'd0, b};
          {model_hi, model_lo} = p;
        end
        F_DIV: begin
          if (b != 32'd0) begin
            na = a[31];
            nb = b[31];
            ma = na ? -a : a;
            mb = nb ? -b : b;
            q = ma / mb;
            rm = ma % mb;
            model_lo = (na != nb) ? -q : q;
            model_hi = na ? -rm : rm;
          end
        end
        F_DIVU: begin
          if (b != 32'd0) begin
            model_lo = a / b;
            model_hi = a % b;
          end
        end
        default: ;
      endcase
    end
    o.hi_out = model_hi;
    o.lo_out = model_lo;
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] rand_funct();
    logic [5:0] codes[24];
    codes = '{F_SLL, F_SRL, F_SRA, F_SLLV, F_SRLV, F_SRAV, F_JR, F_MFHI,
              F_MTHI, F_MFLO, F_MTLO, F_MULT, F_MULTU, F_DIV, F_DIVU, F_ADD,
              F_ADDU, F_SUB, F_SUBU, F_AND, F_OR, F_XOR, F_SLT, F_SLTU};
    if ($urandom_range(0, 19) == 0) return 6'($urandom);
    return codes[$urandom_range(0, 23)];
  endfunction

  task automatic add_request(logic [31:0] ins, logic [31:0] a, logic [31:0] b);
    req_t r;
    r.instruction = ins;
    r.rs_value = a;
    r.rt_value = b;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] r_word(logic [5:0] fn);
    logic [31:0] w;
    w = $urandom;
    w[31:26] = 6'd0;
    w[5:0] = fn;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] w;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    errors = 0;
    model_hi = '0;
    model_lo = '0;
    stim_done = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 65;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_request(r_word(F_ADD), 32'h7FFF_FFFF, 32'h0000_0001);
    add_request(r_word(F_ADD), 32'h8000_0000, 32'hFFFF_FFFF);
    add_request(r_word(F_SUB), 32'h8000_0000, 32'h0000_0001);
    add_request(r_word(F_SUB), 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_request(r_word(F_ADDU), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(r_word(F_SUBU), 32'h0, 32'h1);
    add_request(r_word(F_SLT), 32'h8000_0000, 32'h7FFF_FFFF);
    add_request(r_word(F_SLTU), 32'h8000_0000, 32'h7FFF_FFFF);
    add_request(r_word(F_SRA) | 32'h7C0, 32'h0, 32'h8000_0000);
    add_request(r_word(F_SRAV), 32'hFFFF_FFFF, 32'h8000_0000);
    add_request(r_word(F_SLLV), 32'hFFFF_FFE1, 32'hFFFF_FFFF);
    add_request(r_word(F_MULT), 32'h8000_0000, 32'h8000_0000);
    add_request(r_word(F_MFHI), 32'h0, 32'h0);
    add_request(r_word(F_MULTU), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(r_word(F_MULT), 32'hFFFF_FFFF, 32'h0000_0005);
    add_request(r_word(F_DIV), 32'h8000_0000, 32'hFFFF_FFFF);
    add_request(r_word(F_DIV), 32'hFFFF_FFF9, 32'h0000_0002);
    add_request(r_word(F_DIV), 32'h1234_5678, 32'h0);
    add_request(r_word(F_DIVU), 32'hFFFF_FFFF, 32'h0);
    add_request(r_word(F_DIVU), 32'hFFFF_FFFF, 32'h0000_0007);
    add_request(r_word(F_MTHI), 32'hDEAD_BEEF, 32'h0);
    add_request(r_word(F_MTLO), 32'hCAFE_F00D, 32'h0);
    add_request(r_word(F_JR), 32'hFFFF_FFFC, 32'h0);
    add_request({6'd3, 26'h3FF_FFFF}, $urandom, $urandom);
    add_request({6'h3F, 26'h0} | 32'h0000_0018, $urandom, $urandom);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 37 : 0;
      for (int i = 0; i < 230; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom;
          if ($urandom_range(0, 1) == 0) w[31:26] = 6'(6'd2 + $urandom_range(0, 1));
        end else begin
          w = r_word(rand_funct());
        end
        add_request(w, rand_operand(), rand_operand());
      end
    end
    wait_drained();
    stim_done = 1'b1;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall and response check
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_rsps.push_back(predict_execute(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %h", $time, out_data);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (exp_rsp !== out_data) begin
            $display("%0t: response mismatch expected %h actual %h",
                     $time, exp_rsp, out_data);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (stim_done);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mrte_pkg.sv
rtl/mrte_muldiv.sv
rtl/mips_r_type_execute.sv
tb/sv/tb_top.sv
